// ===== sv/graph_dfs_parent_tree_assert.svh =====
// Assertion macros used by the checker file.
`ifndef GRAPH_DFS_PARENT_TREE_ASSERT_SVH
`define GRAPH_DFS_PARENT_TREE_ASSERT_SVH

// antecedent and consequent in the same cycle
`define GDPT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent in the cycle after the antecedent
`define GDPT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/gdpt_pkg.sv =====
`default_nettype none
package gdpt_pkg;

	localparam int NODE_W = 6;
	localparam int OP_W   = 2;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR  = 2'd0,
		OP_ADD    = 2'd1,
		OP_SEARCH = 2'd2,
		OP_PATH   = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_CLEAR,
		CMD_ADD_RD,
		CMD_ADD_WR,
		CMD_S_INIT,
		CMD_POP,
		CMD_DEG,
		CMD_SCAN,
		CMD_E_RD,
		CMD_OUT_SRCH,
		CMD_OUT_ADDERR,
		CMD_OUT_PERR,
		CMD_P_INIT,
		CMD_P_STEP,
		CMD_P_ADV,
		CMD_P_SRC,
		CMD_PE_RD,
		CMD_OUT_PATH
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic add_err;
		logic ab_bad;
		logic sp_zero;
		logic scan_done;
		logic idx_last;
		logic at_src;
		logic walk_err;
		logic pidx_zero;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

// ===== sv/gdpt_dp.sv =====
`default_nettype none
module gdpt_dp import gdpt_pkg::*; #(
	parameter int NODE_COUNT = 64,
	parameter int MAX_DEGREE = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	output status_t                status,
	input  wire logic [OP_W-1:0]   in_op,
	input  wire logic [NODE_W-1:0] in_node,
	input  wire logic [NODE_W-1:0] in_other,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [NODE_W-1:0]      out_node,
	output logic [NODE_W-1:0]      out_parent,
	output logic                   out_has_parent,
	output logic                   out_error,
	output logic                   out_last
);

	localparam int NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int DW = $clog2(MAX_DEGREE + 1);
	localparam int AW = $clog2(NODE_COUNT * MAX_DEGREE);

	typedef logic [NW-1:0] nid_t;

	op_t               op_q;
	logic [NODE_W-1:0] a_q, b_q, v_q;
	logic [DW-1:0]     k_q;
	logic [NW:0]       sp_q;
	nid_t              idx_q, len_q, pidx_q, top_q, prev_q;

	nid_t          adj_mem  [NODE_COUNT*MAX_DEGREE];
	logic [DW-1:0] deg_mem  [NODE_COUNT];
	nid_t          par_mem  [NODE_COUNT];
	nid_t          stk_mem  [NODE_COUNT];
	nid_t          path_mem [NODE_COUNT];

	nid_t          adj_rd_q, par_rd_q, stk_rd_q, path_rd_q;
	logic [DW-1:0] deg_rd_q;
	logic          deg_rv_q;

	logic [NODE_COUNT-1:0] deg_vld_q, vis_q, pv_q;
	logic                  pend_s1;

	logic          a_ok, b_ok, out_free, scan_more, w_take;
	nid_t          a_idx, b_idx, v_idx;
	logic [DW-1:0] deg_cur;
	nid_t          deg_addr, par_addr;
	logic [AW-1:0] add_addr, scan_addr;

	assign a_ok      = {1'b0, a_q} < (NODE_W+1)'(NODE_COUNT);
	assign b_ok      = {1'b0, b_q} < (NODE_W+1)'(NODE_COUNT);
	assign a_idx     = a_q[NW-1:0];
	assign b_idx     = b_q[NW-1:0];
	assign v_idx     = v_q[NW-1:0];
	assign deg_cur   = deg_rv_q ? deg_rd_q : '0;
	assign scan_more = k_q < deg_cur;
	assign add_addr  = AW'(int'(a_idx) * MAX_DEGREE + int'(deg_cur));
	assign scan_addr = AW'(int'(v_idx) * MAX_DEGREE + int'(k_q));
	assign deg_addr  = (cmd == CMD_DEG) ? stk_rd_q : a_idx;
	assign par_addr  = (cmd == CMD_E_RD) ? idx_q : v_idx;
	assign out_free  = !out_valid || out_ready;
	// neighbour from the scan pipeline that is new to the search
	assign w_take    = pend_s1 && ({1'b0, adj_rd_q} < (NW+1)'(NODE_COUNT)) && !vis_q[adj_rd_q];

	always_comb begin
		status.op        = op_q;
		status.add_err   = !a_ok || !b_ok || (deg_cur >= DW'(MAX_DEGREE));
		status.ab_bad    = !a_ok || !b_ok;
		status.sp_zero   = sp_q == '0;
		status.scan_done = !scan_more;
		status.idx_last  = idx_q == NW'(NODE_COUNT - 1);
		status.at_src    = v_q == a_q;
		status.walk_err  = !pv_q[v_idx] || (len_q == NW'(NODE_COUNT - 1));
		status.pidx_zero = pidx_q == '0;
		status.out_free  = out_free;
	end

	// memories
	always_ff @(posedge clk) begin
		if (cmd == CMD_ADD_WR && !status.add_err) begin
			adj_mem[add_addr] <= b_idx;
			deg_mem[a_idx]    <= deg_cur + DW'(1);
		end
		if (cmd == CMD_SCAN && scan_more)
			adj_rd_q <= adj_mem[scan_addr];
		if (cmd == CMD_ADD_RD || cmd == CMD_DEG)
			deg_rd_q <= deg_mem[deg_addr];
		if (w_take)
			par_mem[adj_rd_q] <= v_idx;
		if (cmd == CMD_E_RD || cmd == CMD_P_STEP)
			par_rd_q <= par_mem[par_addr];
		if (cmd == CMD_S_INIT)
			stk_mem[0] <= a_idx;
		else if (w_take && sp_q < (NW+1)'(NODE_COUNT))
			stk_mem[sp_q[NW-1:0]] <= adj_rd_q;
		if (cmd == CMD_POP)
			stk_rd_q <= stk_mem[NW'(sp_q - (NW+1)'(1))];
		if (cmd == CMD_P_STEP)
			path_mem[len_q] <= v_idx;
		else if (cmd == CMD_P_SRC)
			path_mem[len_q] <= a_idx;
		if (cmd == CMD_PE_RD)
			path_rd_q <= path_mem[pidx_q];
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LOAD: begin
				op_q <= op_t'(in_op);
				a_q  <= in_node;
				b_q  <= in_other;
			end
			CMD_S_INIT: idx_q <= '0;
			CMD_DEG: begin
				v_q <= NODE_W'(stk_rd_q);
				k_q <= '0;
			end
			CMD_SCAN: if (scan_more) k_q <= k_q + DW'(1);
			CMD_P_INIT: begin
				v_q   <= b_q;
				len_q <= '0;
			end
			CMD_P_STEP: len_q <= len_q + NW'(1);
			CMD_P_ADV:  v_q <= NODE_W'(par_rd_q);
			CMD_P_SRC: begin
				pidx_q <= len_q;
				top_q  <= len_q;
			end
			CMD_OUT_SRCH: idx_q <= idx_q + NW'(1);
			CMD_OUT_PATH: begin
				prev_q <= path_rd_q;
				pidx_q <= pidx_q - NW'(1);
			end
			default: ;
		endcase
		if (cmd == CMD_ADD_RD || cmd == CMD_DEG)
			deg_rv_q <= deg_vld_q[deg_addr];
	end

	// control flops
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_vld_q <= '0;
			vis_q     <= '0;
			pv_q      <= '0;
			sp_q      <= '0;
			pend_s1   <= 1'b0;
		end else begin
			pend_s1 <= (cmd == CMD_SCAN) && scan_more;
			if (cmd == CMD_CLEAR)
				deg_vld_q <= '0;
			else if (cmd == CMD_ADD_WR && !status.add_err)
				deg_vld_q[a_idx] <= 1'b1;
			if (cmd == CMD_S_INIT) begin
				pv_q <= '0;
				if (a_ok) begin
					vis_q <= {{(NODE_COUNT-1){1'b0}}, 1'b1} << a_idx;
					sp_q  <= (NW+1)'(1);
				end else begin
					vis_q <= '0;
					sp_q  <= '0;
				end
			end else if (cmd == CMD_POP) begin
				sp_q <= sp_q - (NW+1)'(1);
			end else if (w_take) begin
				vis_q[adj_rd_q] <= 1'b1;
				pv_q[adj_rd_q]  <= 1'b1;
				if (sp_q < (NW+1)'(NODE_COUNT))
					sp_q <= sp_q + (NW+1)'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (cmd == CMD_OUT_SRCH || cmd == CMD_OUT_ADDERR ||
				cmd == CMD_OUT_PERR || cmd == CMD_OUT_PATH)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_OUT_ADDERR: begin
				out_node       <= a_q;
				out_parent     <= b_q;
				out_has_parent <= 1'b0;
				out_error      <= 1'b1;
				out_last       <= 1'b1;
			end
			CMD_OUT_PERR: begin
				out_node       <= v_q;
				out_parent     <= '0;
				out_has_parent <= 1'b0;
				out_error      <= 1'b1;
				out_last       <= 1'b1;
			end
			CMD_OUT_SRCH: begin
				out_node       <= NODE_W'(idx_q);
				out_parent     <= pv_q[idx_q] ? NODE_W'(par_rd_q) : '0;
				out_has_parent <= pv_q[idx_q];
				out_error      <= 1'b0;
				out_last       <= status.idx_last;
			end
			CMD_OUT_PATH: begin
				out_node       <= NODE_W'(path_rd_q);
				out_parent     <= (pidx_q != top_q) ? NODE_W'(prev_q) : '0;
				out_has_parent <= pidx_q != top_q;
				out_error      <= 1'b0;
				out_last       <= status.pidx_zero;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== sv/gdpt_ctrl.sv =====
`default_nettype none
module gdpt_ctrl import gdpt_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire status_t status,
	output cmd_t         cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_ADD_WR,
		ST_POP,
		ST_DEG,
		ST_SCAN,
		ST_EMIT_RD,
		ST_EMIT_WR,
		ST_WALK,
		ST_ADV,
		ST_PE_RD,
		ST_PE_WR
	} state_t;

	state_t state_q, state_nx;

	assign in_ready = state_q == ST_IDLE;

	always_comb begin
		cmd      = CMD_NONE;
		state_nx = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) begin
				cmd      = CMD_LOAD;
				state_nx = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				case (status.op)
					OP_CLEAR: begin
						cmd      = CMD_CLEAR;
						state_nx = ST_IDLE;
					end
					OP_ADD: begin
						cmd      = CMD_ADD_RD;
						state_nx = ST_ADD_WR;
					end
					OP_SEARCH: begin
						cmd      = CMD_S_INIT;
						state_nx = ST_POP;
					end
					OP_PATH: begin
						cmd      = CMD_P_INIT;
						state_nx = ST_WALK;
					end
					default: state_nx = ST_IDLE;
				endcase
			end
			ST_ADD_WR: begin
				if (!status.add_err) begin
					cmd      = CMD_ADD_WR;
					state_nx = ST_IDLE;
				end else if (status.out_free) begin
					cmd      = CMD_OUT_ADDERR;
					state_nx = ST_IDLE;
				end
			end
			ST_POP: begin
				if (status.sp_zero) begin
					cmd      = CMD_E_RD;
					state_nx = ST_EMIT_WR;
				end else begin
					cmd      = CMD_POP;
					state_nx = ST_DEG;
				end
			end
			ST_DEG: begin
				cmd      = CMD_DEG;
				state_nx = ST_SCAN;
			end
			ST_SCAN: begin
				// last issued entry is still handled on the way out
				cmd = CMD_SCAN;
				if (status.scan_done)
					state_nx = ST_POP;
			end
			ST_EMIT_RD: begin
				cmd      = CMD_E_RD;
				state_nx = ST_EMIT_WR;
			end
			ST_EMIT_WR: if (status.out_free) begin
				cmd      = CMD_OUT_SRCH;
				state_nx = status.idx_last ? ST_IDLE : ST_EMIT_RD;
			end
			ST_WALK: begin
				if (status.ab_bad || (!status.at_src && status.walk_err)) begin
					if (status.out_free) begin
						cmd      = CMD_OUT_PERR;
						state_nx = ST_IDLE;
					end
				end else if (status.at_src) begin
					cmd      = CMD_P_SRC;
					state_nx = ST_PE_RD;
				end else begin
					cmd      = CMD_P_STEP;
					state_nx = ST_ADV;
				end
			end
			ST_ADV: begin
				cmd      = CMD_P_ADV;
				state_nx = ST_WALK;
			end
			ST_PE_RD: begin
				cmd      = CMD_PE_RD;
				state_nx = ST_PE_WR;
			end
			ST_PE_WR: if (status.out_free) begin
				cmd      = CMD_OUT_PATH;
				state_nx = status.pidx_zero ? ST_IDLE : ST_PE_RD;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nx;
	end

endmodule
`default_nettype wire

// ===== sv/graph_dfs_parent_tree.sv =====
// Add edge: an error result waits in the write state while the output is full.
// Search: pop each node, read its degree, scan its neighbours; then one result per node.
// Path query: walk parent links, then emit the path; one shared parent-memory read port.
// One transaction at a time; a waiting result does not block the next input.
// Reset clears degree counts, visit marks and parent-valid flags; the adjacency,
// parent, stack and path memories are not cleared and need no clearing pass.
`default_nettype none
module graph_dfs_parent_tree import gdpt_pkg::*; #(
	parameter int NODE_COUNT = 64,
	parameter int MAX_DEGREE = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // [5:0] node, [11:6] other_node, rest zero
	input  wire logic [1:0]  s_axis_tuser,  // [1:0] operation
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // [5:0] node_id, [11:6] parent_id, rest zero
	output logic [1:0]       m_axis_tuser,  // [0] has_parent, [1] error
	output logic             m_axis_tlast
);

	cmd_t              cmd;
	status_t           status;
	logic [NODE_W-1:0] out_node, out_parent;
	logic              out_has_parent, out_error;

	gdpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	gdpt_dp #(
		.NODE_COUNT (NODE_COUNT),
		.MAX_DEGREE (MAX_DEGREE)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.in_op          (s_axis_tuser),
		.in_node        (s_axis_tdata[5:0]),
		.in_other       (s_axis_tdata[11:6]),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_node       (out_node),
		.out_parent     (out_parent),
		.out_has_parent (out_has_parent),
		.out_error      (out_error),
		.out_last       (m_axis_tlast)
	);

	assign m_axis_tdata = {4'b0000, out_parent, out_node};
	assign m_axis_tuser = {out_error, out_has_parent};

endmodule
`default_nettype wire

// ===== sv/gdpt_chk.sv =====
`default_nettype none
`include "graph_dfs_parent_tree_assert.svh"
module gdpt_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [15:0] s_axis_tdata,
	input wire logic [1:0]  s_axis_tuser,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [15:0] m_axis_tdata,
	input wire logic [1:0]  m_axis_tuser,
	input wire logic        m_axis_tlast
);

	`GDPT_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result changed while stalled")
	`GDPT_ASSERT_NOW(a_err_last, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast, "error result not last")
	`GDPT_ASSERT_NOW(a_err_noparent, m_axis_tvalid && m_axis_tuser[1], !m_axis_tuser[0], "error result with parent")
	`GDPT_ASSERT_NOW(a_noparent_zero, m_axis_tvalid && !m_axis_tuser[0] && !m_axis_tuser[1], m_axis_tdata[11:6] == 6'd0, "parent id set without parent")

endmodule

bind graph_dfs_parent_tree gdpt_chk u_gdpt_chk (.*);
`default_nettype wire

// ===== verif/graph_dfs_parent_tree_test.sv =====
`default_nettype none
module graph_dfs_parent_tree_test;
	import gdpt_pkg::*;

	localparam int NODES   = 64;
	localparam int DEGREE  = 8;
	localparam int IDLE_LIMIT = 20000;

	typedef struct {
		logic [5:0] node_id;
		logic [5:0] parent_id;
		logic       has_parent;
		logic       error;
		logic       last;
	} tree_result_t;

	class tree_scoreboard;
		logic [5:0]   adj [NODES][DEGREE];
		int           degree [NODES];
		bit           mark [NODES];
		logic [5:0]   parent [NODES];
		bit           parent_ok [NODES];
		tree_result_t pending_results[$];
		int           errors;

		function new();
			foreach (degree[i]) begin
				degree[i] = 0;
				mark[i] = 0;
				parent_ok[i] = 0;
			end
			errors = 0;
		endfunction

		function void push_result(logic [5:0] id, logic [5:0] par, bit hp, bit err, bit lst);
			tree_result_t r;
			r.node_id = id;
			r.parent_id = par;
			r.has_parent = hp;
			r.error = err;
			r.last = lst;
			pending_results.push_back(r);
		endfunction

		function void run_dfs(logic [5:0] src);
			logic [5:0] stk [NODES];
			int sp;
			logic [5:0] v;
			logic [5:0] w;
			foreach (mark[i]) begin
				mark[i] = 0;
				parent_ok[i] = 0;
			end
			sp = 0;
			mark[src] = 1;
			stk[sp] = src;
			sp++;
			while (sp > 0) begin
				sp--;
				v = stk[sp];
				for (int k = 0; k < degree[v]; k++) begin
					w = adj[v][k];
					if (!mark[w]) begin
						parent[w] = v;
						parent_ok[w] = 1;
						mark[w] = 1;
						if (sp < NODES) begin
							stk[sp] = w;
							sp++;
						end
					end
				end
			end
		endfunction

		function void note_input(op_t op, logic [5:0] a, logic [5:0] b);
			logic [5:0] route [NODES];
			int len;
			logic [5:0] v;
			case (op)
				OP_CLEAR: begin
					foreach (degree[i])
						degree[i] = 0;
				end
				OP_ADD: begin
					if (degree[a] >= DEGREE) begin
						push_result(a, b, 1'b0, 1'b1, 1'b1);
					end else begin
						adj[a][degree[a]] = b;
						degree[a]++;
					end
				end
				OP_SEARCH: begin
					run_dfs(a);
					for (int i = 0; i < NODES; i++)
						push_result(6'(i), parent_ok[i] ? parent[i] : 6'd0, parent_ok[i], 1'b0,
							i == NODES - 1);
				end
				OP_PATH: begin
					len = 0;
					v = b;
					while (v != a) begin
						if (!parent_ok[v] || len >= NODES - 1) begin
							push_result(v, 6'd0, 1'b0, 1'b1, 1'b1);
							return;
						end
						route[len] = v;
						len++;
						v = parent[v];
					end
					route[len] = a;
					len++;
					for (int k = 0; k < len; k++)
						push_result(route[len-1-k], k > 0 ? route[len-k] : 6'd0, k > 0, 1'b0,
							k == len - 1);
				end
				default: ;
			endcase
		endfunction

		function void check_result(tree_result_t got);
			tree_result_t want;
			if (pending_results.size() == 0) begin
				$error("unexpected result node_id=%0d", got.node_id);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got.node_id !== want.node_id) begin
				$error("node_id: expected %0d, got %0d", want.node_id, got.node_id);
				errors++;
			end
			if (got.parent_id !== want.parent_id) begin
				$error("parent_id: expected %0d, got %0d", want.parent_id, got.parent_id);
				errors++;
			end
			if (got.has_parent !== want.has_parent) begin
				$error("has_parent: expected %0b, got %0b", want.has_parent, got.has_parent);
				errors++;
			end
			if (got.error !== want.error) begin
				$error("error: expected %0b, got %0b", want.error, got.error);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = 0;
	logic [1:0]  s_axis_tuser = 0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [15:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	graph_dfs_parent_tree dut (
		.clk, .arst_n,
		.s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
	);

	tree_scoreboard sb = new();
	bit  rx_hold = 0;
	int  rx_mode = 0;
	int  rx_mode_left = 0;
	int  burst_left = 0;
	int  idle_cycles = 0;

	always #5 clk = ~clk;

	// receiver stall pattern, independent of the sender
	always @(negedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_mode_left = $urandom_range(20, 300);
		end else
			rx_mode_left--;
		if (!arst_n || rx_hold)
			m_axis_tready = 0;
		else case (rx_mode)
			0: m_axis_tready = 1;
			1: m_axis_tready = 1'($urandom_range(0, 1));
			default: m_axis_tready = ($urandom_range(0, 4) == 0);
		endcase
	end

	always @(posedge clk) begin
		tree_result_t r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			r.node_id = m_axis_tdata[5:0];
			r.parent_id = m_axis_tdata[11:6];
			r.has_parent = m_axis_tuser[0];
			r.error = m_axis_tuser[1];
			r.last = m_axis_tlast;
			sb.check_result(r);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	task automatic send(op_t op, logic [5:0] a, logic [5:0] b);
		int gap;
		s_axis_tvalid = 1;
		s_axis_tuser = op;
		s_axis_tdata = {4'b0, b, a};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_input(op, a, b);
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_axis_tvalid = 0;
				repeat (gap) @(negedge clk);
			end
		end else
			burst_left--;
	endtask

	task automatic drain();
		s_axis_tvalid = 0;
		while (sb.pending_results.size() != 0)
			@(negedge clk);
		// a clear or an edge load may still be in flight
		repeat (10) @(negedge clk);
	endtask

	task automatic hold_receiver();
		rx_hold = 1;
		repeat (2500) @(negedge clk);
		rx_hold = 0;
	endtask

	function automatic logic [5:0] rnd_node();
		return 6'($urandom_range(0, 63));
	endfunction

	function automatic logic [5:0] pick(logic [5:0] base);
		if ($urandom_range(0, 9) == 0)
			return rnd_node();
		return 6'(base + $urandom_range(0, 11));
	endfunction

	task automatic random_graphs(int count);
		int sent;
		logic [5:0] base;
		logic [5:0] src;
		sent = 0;
		while (sent < count) begin
			base = 6'($urandom_range(0, 52));
			if ($urandom_range(0, 3) == 0) begin
				send(OP_CLEAR, rnd_node(), rnd_node());
				sent++;
			end
			repeat ($urandom_range(4, 24)) begin
				send(OP_ADD, pick(base), pick(base));
				sent++;
			end
			src = pick(base);
			send(OP_SEARCH, src, rnd_node());
			sent++;
			repeat ($urandom_range(2, 6)) begin
				send(OP_PATH, $urandom_range(0, 5) == 0 ? pick(base) : src, pick(base));
				sent++;
			end
			// noise: stray items out of sequence
			if ($urandom_range(0, 2) == 0) begin
				send(op_t'($urandom_range(0, 3)), rnd_node(), rnd_node());
				sent++;
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		send(OP_SEARCH, 6'd5, 6'd0);
		send(OP_PATH, 6'd5, 6'd5);
		send(OP_PATH, 6'd5, 6'd9);
		send(OP_ADD, 6'd5, 6'd9);
		send(OP_ADD, 6'd9, 6'd63);
		send(OP_ADD, 6'd63, 6'd0);
		send(OP_ADD, 6'd0, 6'd5);
		send(OP_ADD, 6'd0, 6'd63);
		send(OP_ADD, 6'd0, 6'd0);
		for (int i = 10; i < 18; i++)
			send(OP_ADD, 6'd3, 6'(i));
		send(OP_ADD, 6'd3, 6'd18);  // list already full
		send(OP_ADD, 6'd63, 6'd3);
		send(OP_SEARCH, 6'd5, 6'd63);
		send(OP_PATH, 6'd5, 6'd17);
		send(OP_PATH, 6'd5, 6'd0);
		send(OP_PATH, 6'd9, 6'd3);  // ends at a source that is not the search root
		send(OP_CLEAR, 6'd63, 6'd63);
		send(OP_SEARCH, 6'd63, 6'd0);
		send(OP_PATH, 6'd63, 6'd0);
		drain();

		fork
			hold_receiver();
		join_none
		random_graphs(150);
		drain();
		random_graphs(155);
		drain();

		repeat (1500) @(posedge clk);
		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/gdpt_pkg.sv
sv/gdpt_dp.sv
sv/gdpt_ctrl.sv
sv/graph_dfs_parent_tree.sv
sv/gdpt_chk.sv
verif/graph_dfs_parent_tree_test.sv
